### sv/i2cm_pkg.sv
// shared types, codes and constants of the tick-driven i2c master
`default_nettype none

package i2cm_pkg;

   // widths
   localparam int unsigned CmdW  = 3;
   localparam int unsigned HalfW = 10;
   localparam int unsigned ByteW = 8;

   // command codes
   localparam logic [CmdW-1:0] CMD_NONE      = 3'd0;
   localparam logic [CmdW-1:0] CMD_START     = 3'd1;
   localparam logic [CmdW-1:0] CMD_STOP      = 3'd2;
   localparam logic [CmdW-1:0] CMD_WRITE     = 3'd3;
   localparam logic [CmdW-1:0] CMD_READ_ACK  = 3'd4;
   localparam logic [CmdW-1:0] CMD_READ_NACK = 3'd5;
   localparam logic [CmdW-1:0] CMD_READ_TIME = 3'd6;
   localparam logic [CmdW-1:0] CMD_SET_REG   = 3'd7;

   // read-time transaction steps
   localparam logic [2:0] RT_START    = 3'd0;
   localparam logic [2:0] RT_WR_ADDR  = 3'd1;
   localparam logic [2:0] RT_WR_PTR   = 3'd2;
   localparam logic [2:0] RT_RESTART  = 3'd3;
   localparam logic [2:0] RT_WR_RADDR = 3'd4;
   localparam logic [2:0] RT_READ     = 3'd5;
   localparam logic [2:0] RT_STOP     = 3'd6;

   // set-register transaction steps
   localparam logic [2:0] SR_START   = 3'd0;
   localparam logic [2:0] SR_WR_ADDR = 3'd1;
   localparam logic [2:0] SR_WR_REG  = 3'd2;
   localparam logic [2:0] SR_WR_DATA = 3'd3;
   localparam logic [2:0] SR_STOP    = 3'd4;

   // bus constants
   localparam logic [ByteW-1:0] ADDR_WRITE   = 8'hD0;
   localparam logic [ByteW-1:0] ADDR_READ    = 8'hD1;
   localparam logic [ByteW-1:0] TIME_POINTER = 8'h00;
   localparam logic [3:0]       BITS_PER_BYTE = 4'd8;
   localparam logic [2:0]       RT_ACK_BYTES  = 3'd6;
   localparam logic [2:0]       RT_LAST_BYTE  = 3'd7;
   localparam logic [2:0]       RT_DOW_INDEX  = 3'd3;
   localparam logic [HalfW-1:0] HALF_RESET    = 10'd5;

   // bus phases, one-hot
   typedef enum logic [12:0] {
      PH_IDLE  = 13'b0_0000_0000_0001,
      PH_ST_A  = 13'b0_0000_0000_0010,
      PH_ST_B  = 13'b0_0000_0000_0100,
      PH_SP_A  = 13'b0_0000_0000_1000,
      PH_SP_B  = 13'b0_0000_0001_0000,
      PH_WR_LO = 13'b0_0000_0010_0000,
      PH_WR_HI = 13'b0_0000_0100_0000,
      PH_WA_LO = 13'b0_0000_1000_0000,
      PH_WA_HI = 13'b0_0001_0000_0000,
      PH_RD_LO = 13'b0_0010_0000_0000,
      PH_RD_HI = 13'b0_0100_0000_0000,
      PH_RA_LO = 13'b0_1000_0000_0000,
      PH_RA_HI = 13'b1_0000_0000_0000
   } phase_type;

   // one classified tick item
   typedef struct packed {
      logic             has_cmd;
      logic [CmdW-1:0]  cmd;
      logic [ByteW-1:0] tx_byte;
      logic [ByteW-1:0] reg_addr;
      logic             sda_in;
   } item_type;

   // first phase of a bus primitive
   typedef struct packed {
      phase_type        phase;
      logic             load;
      logic [ByteW-1:0] data;
   } prim_type;

   // one result transfer
   typedef struct packed {
      logic             scl_low;
      logic             sda_low;
      logic             busy_res;
      logic             byte_valid;
      logic [ByteW-1:0] rx_byte;
      logic [2:0]       rx_index;
      logic             nack_seen;
      logic             cmd_done;
   } res_type;

endpackage

`default_nettype wire

### sv/i2cm_front.sv
// front end: accepts tick transfers, classifies them and queues them for the engine
`default_nettype none

module i2cm_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [i2cm_pkg::CmdW-1:0]   req_cmd,
   input  wire logic [i2cm_pkg::ByteW-1:0]  req_tx_byte,
   input  wire logic [i2cm_pkg::ByteW-1:0]  req_reg_addr,
   input  wire logic                        req_sda_in,
   output logic                             q_valid,
   input  wire logic                        q_stall,
   output i2cm_pkg::item_type               q_item
);

   i2cm_pkg::item_type q_ff [2];
   i2cm_pkg::item_type item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // classify the incoming tick
   always_comb begin
      item.has_cmd  = (req_cmd != i2cm_pkg::CMD_NONE);
      item.cmd      = req_cmd;
      item.tx_byte  = req_tx_byte;
      item.reg_addr = req_reg_addr;
      item.sda_in   = req_sda_in;
   end

   // two-entry queue control
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && !q_stall;
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

### sv/i2cm_engine.sv
// back end: bus phase sequencer, transaction steps and result register
`default_nettype none

module i2cm_engine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [i2cm_pkg::HalfW-1:0]  csr_wr_data,
   input  wire logic                        q_valid,
   output logic                             q_stall,
   input  wire i2cm_pkg::item_type          q_item,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output i2cm_pkg::res_type                rsp_res
);

   i2cm_pkg::phase_type         phase_ff, phase_in;
   logic [i2cm_pkg::HalfW-1:0]  half_ff, half_in;
   logic [i2cm_pkg::HalfW-1:0]  tick_ff, tick_in;
   logic [3:0]                  bit_ff, bit_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [2:0]                  step_ff, step_in;
   logic [2:0]                  byte_cnt_ff, byte_cnt_in;
   logic [2:0]                  pend_ff, pend_in;
   logic [7:0]                  held_value_ff, held_value_in;
   logic [7:0]                  held_addr_ff, held_addr_in;
   logic                        nack_ff, nack_in;
   logic                        hold_scl_ff, hold_scl_in;
   logic                        hold_sda_ff, hold_sda_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::res_type           res_ff, res_in;

   logic [i2cm_pkg::HalfW-1:0]  half_eff;
   logic                        pop;
   logic                        prim_end, prim_scl, prim_sda, cmd_end;
   logic                        bit_low, ack_low;
   i2cm_pkg::prim_type          prim;

   // first phase of the primitive chosen by command and step
   function automatic i2cm_pkg::prim_type begin_prim(
      input logic [2:0] pc,
      input logic [2:0] ts,
      input logic [7:0] hv,
      input logic [7:0] ha
   );
      i2cm_pkg::prim_type p;
      p.phase = i2cm_pkg::PH_IDLE;
      p.load  = 1'b0;
      p.data  = hv;
      case (pc)
         i2cm_pkg::CMD_START: p.phase = i2cm_pkg::PH_ST_A;
         i2cm_pkg::CMD_STOP:  p.phase = i2cm_pkg::PH_SP_A;
         i2cm_pkg::CMD_WRITE: begin
            p.phase = i2cm_pkg::PH_WR_LO;
            p.load  = 1'b1;
         end
         i2cm_pkg::CMD_READ_ACK, i2cm_pkg::CMD_READ_NACK: p.phase = i2cm_pkg::PH_RD_LO;
         i2cm_pkg::CMD_READ_TIME: begin
            case (ts)
               i2cm_pkg::RT_START, i2cm_pkg::RT_RESTART: p.phase = i2cm_pkg::PH_ST_A;
               i2cm_pkg::RT_WR_ADDR: begin
                  p.phase = i2cm_pkg::PH_WR_LO;
                  p.load  = 1'b1;
                  p.data  = i2cm_pkg::ADDR_WRITE;
               end
               i2cm_pkg::RT_WR_PTR: begin
                  p.phase = i2cm_pkg::PH_WR_LO;
                  p.load  = 1'b1;
                  p.data  = i2cm_pkg::TIME_POINTER;
               end
               i2cm_pkg::RT_WR_RADDR: begin
                  p.phase = i2cm_pkg::PH_WR_LO;
                  p.load  = 1'b1;
                  p.data  = i2cm_pkg::ADDR_READ;
               end
               i2cm_pkg::RT_READ: p.phase = i2cm_pkg::PH_RD_LO;
               i2cm_pkg::RT_STOP: p.phase = i2cm_pkg::PH_SP_A;
               default: p.phase = i2cm_pkg::PH_IDLE;
            endcase
         end
         i2cm_pkg::CMD_SET_REG: begin
            case (ts)
               i2cm_pkg::SR_START: p.phase = i2cm_pkg::PH_ST_A;
               i2cm_pkg::SR_WR_ADDR: begin
                  p.phase = i2cm_pkg::PH_WR_LO;
                  p.load  = 1'b1;
                  p.data  = i2cm_pkg::ADDR_WRITE;
               end
               i2cm_pkg::SR_WR_REG: begin
                  p.phase = i2cm_pkg::PH_WR_LO;
                  p.load  = 1'b1;
                  p.data  = ha;
               end
               i2cm_pkg::SR_WR_DATA: begin
                  p.phase = i2cm_pkg::PH_WR_LO;
                  p.load  = 1'b1;
               end
               i2cm_pkg::SR_STOP: p.phase = i2cm_pkg::PH_SP_A;
               default: p.phase = i2cm_pkg::PH_IDLE;
            endcase
         end
         default: p.phase = i2cm_pkg::PH_IDLE;
      endcase
      return p;
   endfunction

   // handshake with queue and result register
   assign q_stall   = rsp_valid_ff && rsp_stall;
   assign pop       = q_valid && !q_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = res_ff;

   // a zero half period acts as one tick
   assign half_eff = (half_ff == '0) ? {{(i2cm_pkg::HalfW-1){1'b0}}, 1'b1} : half_ff;

   // configuration write
   assign half_in = csr_wr_en ? csr_wr_data : half_ff;

   // one tick of the bus sequencer
   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      step_in       = step_ff;
      byte_cnt_in   = byte_cnt_ff;
      pend_in       = pend_ff;
      held_value_in = held_value_ff;
      held_addr_in  = held_addr_ff;
      nack_in       = nack_ff;
      hold_scl_in   = hold_scl_ff;
      hold_sda_in   = hold_sda_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      prim_end      = 1'b0;
      prim_scl      = 1'b0;
      prim_sda      = 1'b0;
      cmd_end       = 1'b0;
      bit_low       = 1'b0;
      ack_low       = 1'b0;
      prim          = begin_prim(pend_ff, step_ff, held_value_ff, held_addr_ff);

      if (pop) begin
         rsp_valid_in = 1'b1;
         res_in       = '0;

         // take a new command when idle
         if (phase_ff == i2cm_pkg::PH_IDLE && q_item.has_cmd) begin
            pend_in       = q_item.cmd;
            held_value_in = q_item.tx_byte;
            held_addr_in  = q_item.reg_addr;
            step_in       = 3'd0;
            byte_cnt_in   = 3'd0;
            prim          = begin_prim(q_item.cmd, 3'd0, q_item.tx_byte, q_item.reg_addr);
            bit_in        = 4'd0;
            tick_in       = '0;
            phase_in      = prim.phase;
            if (prim.load) begin
               shift_in = prim.data;
            end
         end

         res_in.scl_low = hold_scl_ff;
         res_in.sda_low = hold_sda_ff;

         if (phase_in != i2cm_pkg::PH_IDLE) begin
            bit_low = !shift_in[7];
            ack_low = (pend_in == i2cm_pkg::CMD_READ_ACK) ||
                      (pend_in == i2cm_pkg::CMD_READ_TIME && byte_cnt_in < i2cm_pkg::RT_ACK_BYTES);
            res_in.busy_res = 1'b1;

            // line drive of this half period
            case (phase_in)
               i2cm_pkg::PH_ST_A: begin
                  res_in.scl_low = 1'b0; res_in.sda_low = 1'b0;
               end
               i2cm_pkg::PH_ST_B: begin
                  res_in.scl_low = 1'b0; res_in.sda_low = 1'b1;
               end
               i2cm_pkg::PH_SP_A: begin
                  res_in.scl_low = 1'b1; res_in.sda_low = 1'b1;
               end
               i2cm_pkg::PH_SP_B: begin
                  res_in.scl_low = 1'b0; res_in.sda_low = 1'b1;
               end
               i2cm_pkg::PH_WR_LO: begin
                  res_in.scl_low = 1'b1; res_in.sda_low = bit_low;
               end
               i2cm_pkg::PH_WR_HI: begin
                  res_in.scl_low = 1'b0; res_in.sda_low = bit_low;
               end
               i2cm_pkg::PH_WA_LO, i2cm_pkg::PH_RD_LO: begin
                  res_in.scl_low = 1'b1; res_in.sda_low = 1'b0;
               end
               i2cm_pkg::PH_WA_HI, i2cm_pkg::PH_RD_HI: begin
                  res_in.scl_low = 1'b0; res_in.sda_low = 1'b0;
               end
               i2cm_pkg::PH_RA_LO: begin
                  res_in.scl_low = 1'b1; res_in.sda_low = ack_low;
               end
               i2cm_pkg::PH_RA_HI: begin
                  res_in.scl_low = 1'b0; res_in.sda_low = ack_low;
               end
               default: begin
                  res_in.scl_low = hold_scl_ff; res_in.sda_low = hold_sda_ff;
               end
            endcase

            // half period timing and phase advance
            if ({1'b0, tick_in} + 11'd1 < {1'b0, half_eff}) begin
               tick_in = tick_in + 10'd1;
            end else begin
               tick_in = '0;
               case (phase_in)
                  i2cm_pkg::PH_ST_A: phase_in = i2cm_pkg::PH_ST_B;
                  i2cm_pkg::PH_ST_B: begin
                     prim_end = 1'b1; prim_scl = 1'b0; prim_sda = 1'b1;
                  end
                  i2cm_pkg::PH_SP_A: phase_in = i2cm_pkg::PH_SP_B;
                  i2cm_pkg::PH_SP_B: begin
                     prim_end = 1'b1; prim_scl = 1'b0; prim_sda = 1'b0;
                  end
                  i2cm_pkg::PH_WR_LO: phase_in = i2cm_pkg::PH_WR_HI;
                  i2cm_pkg::PH_WR_HI: begin
                     shift_in = {shift_in[6:0], 1'b0};
                     bit_in   = bit_in + 4'd1;
                     phase_in = (bit_in >= i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::PH_WA_LO
                                                                    : i2cm_pkg::PH_WR_LO;
                  end
                  i2cm_pkg::PH_WA_LO: phase_in = i2cm_pkg::PH_WA_HI;
                  i2cm_pkg::PH_WA_HI: begin
                     nack_in  = q_item.sda_in;
                     prim_end = 1'b1; prim_scl = 1'b1; prim_sda = 1'b0;
                  end
                  i2cm_pkg::PH_RD_LO: phase_in = i2cm_pkg::PH_RD_HI;
                  i2cm_pkg::PH_RD_HI: begin
                     shift_in = {shift_in[6:0], q_item.sda_in};
                     bit_in   = bit_in + 4'd1;
                     if (bit_in >= i2cm_pkg::BITS_PER_BYTE) begin
                        // day of week is read but not passed on
                        if (pend_in == i2cm_pkg::CMD_READ_TIME) begin
                           if (byte_cnt_in != i2cm_pkg::RT_DOW_INDEX) begin
                              res_in.byte_valid = 1'b1;
                              res_in.rx_index   = (byte_cnt_in < i2cm_pkg::RT_DOW_INDEX) ?
                                                  byte_cnt_in : byte_cnt_in - 3'd1;
                           end
                        end else begin
                           res_in.byte_valid = 1'b1;
                        end
                        if (res_in.byte_valid) begin
                           res_in.rx_byte = shift_in;
                        end
                        phase_in = i2cm_pkg::PH_RA_LO;
                     end else begin
                        phase_in = i2cm_pkg::PH_RD_LO;
                     end
                  end
                  i2cm_pkg::PH_RA_LO: phase_in = i2cm_pkg::PH_RA_HI;
                  i2cm_pkg::PH_RA_HI: begin
                     prim_end = 1'b1; prim_scl = 1'b1; prim_sda = 1'b0;
                  end
                  default: phase_in = i2cm_pkg::PH_IDLE;
               endcase
            end

            // primitive finished: next transaction step or command end
            if (prim_end) begin
               hold_scl_in = prim_scl;
               hold_sda_in = prim_sda;
               if (pend_in == i2cm_pkg::CMD_READ_TIME) begin
                  if (step_in inside {i2cm_pkg::RT_WR_ADDR, i2cm_pkg::RT_WR_PTR,
                                      i2cm_pkg::RT_WR_RADDR}) begin
                     step_in = nack_in ? i2cm_pkg::RT_STOP : step_in + 3'd1;
                  end else if (step_in == i2cm_pkg::RT_READ) begin
                     byte_cnt_in = byte_cnt_in + 3'd1;
                     if (byte_cnt_in == i2cm_pkg::RT_LAST_BYTE) begin
                        step_in = i2cm_pkg::RT_STOP;
                     end
                  end else if (step_in >= i2cm_pkg::RT_STOP) begin
                     cmd_end = 1'b1;
                  end else begin
                     step_in = step_in + 3'd1;
                  end
               end else if (pend_in == i2cm_pkg::CMD_SET_REG) begin
                  if (step_in inside {i2cm_pkg::SR_WR_ADDR, i2cm_pkg::SR_WR_REG}) begin
                     step_in = nack_in ? i2cm_pkg::SR_STOP : step_in + 3'd1;
                  end else if (step_in >= i2cm_pkg::SR_STOP) begin
                     cmd_end = 1'b1;
                  end else begin
                     step_in = step_in + 3'd1;
                  end
               end else begin
                  cmd_end = 1'b1;
               end

               if (cmd_end) begin
                  phase_in = i2cm_pkg::PH_IDLE;
                  tick_in  = '0;
               end else begin
                  prim     = begin_prim(pend_in, step_in, held_value_in, held_addr_in);
                  bit_in   = 4'd0;
                  tick_in  = '0;
                  phase_in = prim.phase;
                  if (prim.load) begin
                     shift_in = prim.data;
                  end
               end
            end
         end

         res_in.nack_seen = nack_in;
         res_in.cmd_done  = cmd_end;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cm_pkg::PH_IDLE;
         half_ff       <= i2cm_pkg::HALF_RESET;
         tick_ff       <= '0;
         bit_ff        <= 4'd0;
         shift_ff      <= 8'd0;
         step_ff       <= 3'd0;
         byte_cnt_ff   <= 3'd0;
         pend_ff       <= i2cm_pkg::CMD_NONE;
         held_value_ff <= 8'd0;
         held_addr_ff  <= 8'd0;
         nack_ff       <= 1'b0;
         hold_scl_ff   <= 1'b0;
         hold_sda_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         half_ff       <= half_in;
         tick_ff       <= tick_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         step_ff       <= step_in;
         byte_cnt_ff   <= byte_cnt_in;
         pend_ff       <= pend_in;
         held_value_ff <= held_value_in;
         held_addr_ff  <= held_addr_in;
         nack_ff       <= nack_in;
         hold_scl_ff   <= hold_scl_in;
         hold_sda_ff   <= hold_sda_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

`default_nettype wire

### sv/i2c_master_rtc_reader_core.sv
// tick-driven i2c master with read-time and set-register transactions
// a taken tick transfer passes through the front queue, and its result is registered in the engine result register
// throughput: one tick per cycle while neither the queue nor the result register stalls, set by the bus sequencer
// a two-entry queue between front and engine lets each side stall on its own
// synchronous active-high reset: bus idle, both lines released, half period of five ticks
`default_nettype none

module i2c_master_rtc_reader_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [i2cm_pkg::HalfW-1:0]  csr_wr_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [i2cm_pkg::CmdW-1:0]   req_cmd,
   input  wire logic [i2cm_pkg::ByteW-1:0]  req_tx_byte,
   input  wire logic [i2cm_pkg::ByteW-1:0]  req_reg_addr,
   input  wire logic                        req_sda_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_scl_low,
   output logic                             rsp_sda_low,
   output logic                             rsp_busy_res,
   output logic                             rsp_byte_valid,
   output logic [i2cm_pkg::ByteW-1:0]       rsp_rx_byte,
   output logic [2:0]                       rsp_rx_index,
   output logic                             rsp_nack_seen,
   output logic                             rsp_cmd_done
);

   logic               q_valid;
   logic               q_stall;
   i2cm_pkg::item_type q_item;
   i2cm_pkg::res_type  res;

   // accept and classify tick transfers
   i2cm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_tx_byte  (req_tx_byte),
      .req_reg_addr (req_reg_addr),
      .req_sda_in   (req_sda_in),
      .q_valid      (q_valid),
      .q_stall      (q_stall),
      .q_item       (q_item)
   );

   // run the bus sequencer
   i2cm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_stall     (q_stall),
      .q_item      (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_res     (res)
   );

   // result fields
   assign rsp_scl_low    = res.scl_low;
   assign rsp_sda_low    = res.sda_low;
   assign rsp_busy_res   = res.busy_res;
   assign rsp_byte_valid = res.byte_valid;
   assign rsp_rx_byte    = res.rx_byte;
   assign rsp_rx_index   = res.rx_index;
   assign rsp_nack_seen  = res.nack_seen;
   assign rsp_cmd_done   = res.cmd_done;

endmodule

`default_nettype wire
